// ----- hdl/localization_fault_fallback_supervisor_top_macros.svh -----
// Assertion macros used by the checker file.
`ifndef LOCALIZATION_FAULT_FALLBACK_SUPERVISOR_TOP_MACROS_SVH
`define LOCALIZATION_FAULT_FALLBACK_SUPERVISOR_TOP_MACROS_SVH

// Property checked at every clock edge, reset included.
`define LFFS_ASSERT(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lffs assertion failed");

// Property checked only while reset is released.
`define LFFS_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lffs assertion failed");

`endif

// ----- hdl/lffs_pkg.sv -----
`timescale 1ns / 1ps

package lffs_pkg;

    typedef struct packed {
        logic        operation;
        logic [9:0]  iteration_count;
        logic [15:0] score;
        logic [31:0] time_now_ms;
    } t_in_word;

    typedef struct packed {
        logic        fallback_on;
        logic        mode_changed;
        logic        request_reinit;
        logic [15:0] semi_good_count;
    } t_out_word;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ITERATION_LIMIT      = 3'd0,
        CFG_MISS_COUNT_NEEDED    = 3'd1,
        CFG_GOOD_THRESHOLD       = 3'd2,
        CFG_SEMI_THRESHOLD       = 3'd3,
        CFG_RECOVER_COUNT_NEEDED = 3'd4,
        CFG_RETRY_INTERVAL_MS    = 3'd5
    } t_cfg_index;

    localparam logic OP_ITERATION = 1'b0;
    localparam logic OP_SCORE     = 1'b1;

    localparam logic [9:0]  RST_ITERATION_LIMIT      = 10'd21;
    localparam logic [15:0] RST_MISS_COUNT_NEEDED    = 16'd1;
    localparam logic [15:0] RST_GOOD_THRESHOLD       = 16'd589;
    localparam logic [15:0] RST_SEMI_THRESHOLD       = 16'd512;
    localparam logic [15:0] RST_RECOVER_COUNT_NEEDED = 16'd50;
    localparam logic [31:0] RST_RETRY_INTERVAL_MS    = 32'd80000;

    // The retry timer runs only while the good run is below this.
    localparam logic [15:0] RETRY_GOOD_LIMIT = 16'd5;
    localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

endpackage

// ----- hdl/localization_fault_fallback_supervisor_top.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Word
// input     in         i_valid / o_stall    i_data (lffs_pkg::t_in_word)
// output    out        o_valid / i_stall    o_data (lffs_pkg::t_out_word)
// config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// A word accepted into the input register is written to the result register once the
// output can advance, and its result is then offered from the result register.
// One word is accepted per cycle when the output is not stalled; the supervisor state
// updates as a word moves into the result register.
// Reset is synchronous and active low; it restores all register and state defaults.
// A stall on the output holds the result; the input register still takes one more word,
// and only once it is full is the input stalled as well.

module localization_fault_fallback_supervisor_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  lffs_pkg::t_in_word                    i_data,
    output logic                                  o_stall,
    output logic                                  o_valid,
    output lffs_pkg::t_out_word                   o_data,
    input  logic                                  i_stall,
    input  logic                                  i_cfg_we,
    input  logic [lffs_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [lffs_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import lffs_pkg::*;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + 16'd1;
    endfunction

    // Configuration registers
    logic [9:0]  r_iteration_limit;
    logic [15:0] r_miss_count_needed;
    logic [15:0] r_good_threshold;
    logic [15:0] r_semi_threshold;
    logic [15:0] r_recover_count_needed;
    logic [31:0] r_retry_interval_ms;

    // Pipeline
    logic      r_in_valid;
    t_in_word  r_in_data;
    logic      r_out_valid;
    t_out_word r_out_data;
    t_out_word n_out_data;
    logic      w_advance;
    logic      w_commit;
    logic      w_load;

    // Supervisor state
    logic        r_mode_backup, n_mode_backup;
    logic [15:0] r_miss_run, n_miss_run;
    logic [15:0] r_good_run, n_good_run;
    logic [15:0] r_semi_run, n_semi_run;
    logic [31:0] r_last_retry, n_last_retry;
    logic        r_retry_valid, n_retry_valid;
    logic [31:0] w_elapsed;

    assign w_advance = !r_out_valid || !i_stall;
    assign w_commit  = r_in_valid && w_advance;
    assign w_load    = !r_in_valid || w_advance;
    assign o_stall   = r_in_valid && !w_advance;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out_data;
    assign w_elapsed = r_in_data.time_now_ms - r_last_retry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iteration_limit      <= RST_ITERATION_LIMIT;
            r_miss_count_needed    <= RST_MISS_COUNT_NEEDED;
            r_good_threshold       <= RST_GOOD_THRESHOLD;
            r_semi_threshold       <= RST_SEMI_THRESHOLD;
            r_recover_count_needed <= RST_RECOVER_COUNT_NEEDED;
            r_retry_interval_ms    <= RST_RETRY_INTERVAL_MS;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ITERATION_LIMIT:      r_iteration_limit      <= i_cfg_data[9:0];
                CFG_MISS_COUNT_NEEDED:    r_miss_count_needed    <= i_cfg_data[15:0];
                CFG_GOOD_THRESHOLD:       r_good_threshold       <= i_cfg_data[15:0];
                CFG_SEMI_THRESHOLD:       r_semi_threshold       <= i_cfg_data[15:0];
                CFG_RECOVER_COUNT_NEEDED: r_recover_count_needed <= i_cfg_data[15:0];
                CFG_RETRY_INTERVAL_MS:    r_retry_interval_ms    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_mode_backup = r_mode_backup;
        n_miss_run    = r_miss_run;
        n_good_run    = r_good_run;
        n_semi_run    = r_semi_run;
        n_last_retry  = r_last_retry;
        n_retry_valid = r_retry_valid;
        n_out_data    = '0;

        if (r_in_data.operation == OP_ITERATION) begin
            if (r_in_data.iteration_count >= r_iteration_limit) begin
                n_miss_run = sat_inc(r_miss_run);
                n_semi_run = '0;
                n_good_run = '0;
            end else begin
                n_miss_run = '0;
            end
            if (!r_mode_backup && n_miss_run >= r_miss_count_needed) begin
                n_mode_backup           = 1'b1;
                n_good_run              = '0;
                n_out_data.mode_changed = 1'b1;
            end
        end else begin
            n_semi_run = (r_in_data.score >= r_semi_threshold) ? sat_inc(r_semi_run) : '0;
            n_good_run = (r_in_data.score >= r_good_threshold) ? sat_inc(r_good_run) : '0;

            // The first score in backup only arms the timer; later ones may fire it.
            if (r_mode_backup && n_good_run < RETRY_GOOD_LIMIT) begin
                if (!r_retry_valid) begin
                    n_last_retry  = r_in_data.time_now_ms;
                    n_retry_valid = 1'b1;
                end else if (w_elapsed > r_retry_interval_ms) begin
                    n_out_data.request_reinit = 1'b1;
                    n_last_retry              = r_in_data.time_now_ms;
                end
            end

            if (r_mode_backup && n_good_run >= r_recover_count_needed) begin
                n_mode_backup           = 1'b0;
                n_miss_run              = '0;
                n_good_run              = '0;
                n_out_data.mode_changed = 1'b1;
            end
        end

        n_out_data.fallback_on     = n_mode_backup;
        n_out_data.semi_good_count = n_semi_run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_mode_backup <= 1'b0;
            r_miss_run    <= '0;
            r_good_run    <= '0;
            r_semi_run    <= '0;
            r_last_retry  <= '0;
            r_retry_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_in_valid <= i_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_commit) begin
                r_mode_backup <= n_mode_backup;
                r_miss_run    <= n_miss_run;
                r_good_run    <= n_good_run;
                r_semi_run    <= n_semi_run;
                r_last_retry  <= n_last_retry;
                r_retry_valid <= n_retry_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in_data <= i_data;
        end
        if (w_commit) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ----- hdl/lffs_checker.sv -----
`timescale 1ns / 1ps
`include "localization_fault_fallback_supervisor_top_macros.svh"

module lffs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input lffs_pkg::t_in_word  i_data,
    input logic                o_stall,
    input logic                o_valid,
    input lffs_pkg::t_out_word o_data,
    input logic                i_stall
);
    import lffs_pkg::*;

    // A held result keeps its word until it is taken.
    `LFFS_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_data))

    // The input only stalls behind a stalled, full output.
    `LFFS_ASSERT_RST(a_stall_cause, i_clk, i_rst_n, o_stall |-> o_valid && i_stall)

    // Entering backup happens on iteration reports, which never request a restart.
    `LFFS_ASSERT_RST(a_enter_no_req, i_clk, i_rst_n, o_valid && o_data.mode_changed && o_data.fallback_on |-> !o_data.request_reinit)

    // Reset empties the result register.
    `LFFS_ASSERT(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind localization_fault_fallback_supervisor_top lffs_checker u_lffs_checker (.*);

// ----- test/localization_fault_fallback_supervisor_top_tb.sv -----
`timescale 1ns / 1ps

module localization_fault_fallback_supervisor_top_tb;
    import lffs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned PHASES      = 10;
    localparam int unsigned PHASE_WORDS = 52;

    // Indexes past the register list; writes there must leave the block untouched.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum bit {FAILING, RECOVERING} t_mood;

    class mode_tracker;
        logic [9:0]  iter_limit;
        logic [15:0] miss_needed;
        logic [15:0] good_thr;
        logic [15:0] semi_thr;
        logic [15:0] recover_needed;
        logic [31:0] retry_interval;
        logic        in_backup;
        logic        retry_armed;
        logic [15:0] miss_run;
        logic [15:0] good_run;
        logic [15:0] semi_run;
        logic [31:0] last_retry;
        t_out_word   pending_status[$];
        int unsigned words_in;
        int unsigned checked;
        int unsigned mismatches;
        int unsigned switches;
        int unsigned reinits;

        function new();
            iter_limit     = RST_ITERATION_LIMIT;
            miss_needed    = RST_MISS_COUNT_NEEDED;
            good_thr       = RST_GOOD_THRESHOLD;
            semi_thr       = RST_SEMI_THRESHOLD;
            recover_needed = RST_RECOVER_COUNT_NEEDED;
            retry_interval = RST_RETRY_INTERVAL_MS;
            in_backup      = 1'b0;
            retry_armed    = 1'b0;
            miss_run       = '0;
            good_run       = '0;
            semi_run       = '0;
            last_retry     = '0;
            words_in       = 0;
            checked        = 0;
            mismatches     = 0;
            switches       = 0;
            reinits        = 0;
        endfunction

        function logic [15:0] bump(input logic [15:0] v);
            return (v == COUNT_MAX) ? v : v + 16'd1;
        endfunction

        function void set_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
            case (idx)
                CFG_ITERATION_LIMIT:      iter_limit     = data[9:0];
                CFG_MISS_COUNT_NEEDED:    miss_needed    = data[15:0];
                CFG_GOOD_THRESHOLD:       good_thr       = data[15:0];
                CFG_SEMI_THRESHOLD:       semi_thr       = data[15:0];
                CFG_RECOVER_COUNT_NEEDED: recover_needed = data[15:0];
                CFG_RETRY_INTERVAL_MS:    retry_interval = data;
                default: ;
            endcase
        endfunction

        function void note_word(input t_in_word w);
            logic        changed;
            logic        request;
            logic [31:0] elapsed;
            t_out_word   want;
            changed = 1'b0;
            request = 1'b0;
            if (w.operation == OP_ITERATION) begin
                if (w.iteration_count >= iter_limit) begin
                    miss_run = bump(miss_run);
                    semi_run = '0;
                    good_run = '0;
                end else begin
                    miss_run = '0;
                end
                if (!in_backup && miss_run >= miss_needed) begin
                    in_backup = 1'b1;
                    good_run  = '0;
                    changed   = 1'b1;
                end
            end else begin
                semi_run = (w.score >= semi_thr) ? bump(semi_run) : 16'd0;
                good_run = (w.score >= good_thr) ? bump(good_run) : 16'd0;
                if (in_backup && good_run < RETRY_GOOD_LIMIT) begin
                    if (!retry_armed) begin
                        last_retry  = w.time_now_ms;
                        retry_armed = 1'b1;
                    end else begin
                        // Time wraps, so the difference is taken modulo 2^32.
                        elapsed = w.time_now_ms - last_retry;
                        if (elapsed > retry_interval) begin
                            request    = 1'b1;
                            last_retry = w.time_now_ms;
                        end
                    end
                end
                if (in_backup && good_run >= recover_needed) begin
                    in_backup = 1'b0;
                    miss_run  = '0;
                    good_run  = '0;
                    changed   = 1'b1;
                end
            end
            want.fallback_on     = in_backup;
            want.mode_changed    = changed;
            want.request_reinit  = request;
            want.semi_good_count = semi_run;
            pending_status.push_back(want);
            words_in++;
            if (changed) switches++;
            if (request) reinits++;
        endfunction

        task report(input string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        task check_status(input t_out_word got);
            t_out_word want;
            if (pending_status.size() == 0) begin
                report($sformatf("result word %0h arrived with none pending", got));
                return;
            end
            want = pending_status.pop_front();
            if (got.fallback_on !== want.fallback_on)
                report($sformatf("word %0d fallback_on %0b, expected %0b",
                                 checked, got.fallback_on, want.fallback_on));
            if (got.mode_changed !== want.mode_changed)
                report($sformatf("word %0d mode_changed %0b, expected %0b",
                                 checked, got.mode_changed, want.mode_changed));
            if (got.request_reinit !== want.request_reinit)
                report($sformatf("word %0d request_reinit %0b, expected %0b",
                                 checked, got.request_reinit, want.request_reinit));
            if (got.semi_good_count !== want.semi_good_count)
                report($sformatf("word %0d semi_good_count %0d, expected %0d",
                                 checked, got.semi_good_count, want.semi_good_count));
            checked++;
        endtask
    endclass

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_valid     = 1'b0;
    t_in_word                i_data      = '0;
    logic                    o_stall;
    logic                    o_valid;
    t_out_word               o_data;
    logic                    i_stall     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;

    mode_tracker sb;
    bit          calm = 1'b0;
    t_mood       mood = FAILING;
    logic [31:0] now_ms = '0;
    int unsigned cycle_count = 0;

    localization_fault_fallback_supervisor_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("run stopped at the cycle limit with %0d words pending",
                 sb.pending_status.size());
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_status(o_data);
    end

    initial begin : result_sink
        int unsigned hold;
        forever begin
            hold = calm ? 0 : $urandom_range(0, 6);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    function automatic t_in_word iteration_word(input logic [9:0] count);
        t_in_word w;
        w.operation       = OP_ITERATION;
        w.iteration_count = count;
        w.score           = 16'($urandom);
        w.time_now_ms     = $urandom;
        return w;
    endfunction

    function automatic t_in_word score_word(input logic [15:0] score, input logic [31:0] stamp);
        t_in_word w;
        w.operation       = OP_SCORE;
        w.iteration_count = 10'($urandom);
        w.score           = score;
        w.time_now_ms     = stamp;
        return w;
    endfunction

    function automatic logic [9:0] hit_count();
        return (sb.iter_limit == 10'd0) ? 10'd0 : 10'($urandom_range(0, sb.iter_limit - 1));
    endfunction

    function automatic t_in_word next_word();
        t_in_word    w;
        int unsigned roll;
        logic [31:0] span;
        w.operation       = OP_SCORE;
        w.iteration_count = 10'($urandom);
        w.score           = 16'($urandom);
        w.time_now_ms     = $urandom;
        roll = $urandom_range(0, 99);
        if (mood == RECOVERING) begin
            if ($urandom_range(0, sb.recover_needed + 4) == 0) mood = FAILING;
        end else if ($urandom_range(0, 9) == 0) begin
            mood = RECOVERING;
        end
        if (roll < 3) begin
            w.operation = 1'($urandom);
        end else if (mood == RECOVERING) begin
            // Mostly good scores, so that long runs reach the recovery count.
            if (roll < 5) begin
                w.operation       = OP_ITERATION;
                w.iteration_count = hit_count();
            end else begin
                w.score = sb.good_thr + 16'($urandom_range(0, 64));
                if (w.score < sb.good_thr) w.score = COUNT_MAX;
            end
        end else if (roll < 45) begin
            w.operation       = OP_ITERATION;
            w.iteration_count = sb.iter_limit + 10'($urandom_range(0, 8));
            if (w.iteration_count < sb.iter_limit) w.iteration_count = 10'h3FF;
        end else if (roll < 60) begin
            w.operation       = OP_ITERATION;
            w.iteration_count = hit_count();
        end else begin
            case ($urandom_range(0, 3))
                0: w.score = sb.semi_thr;
                1: w.score = sb.good_thr - 16'd1;
                2: w.score = sb.semi_thr - 16'd1;
                default: ;
            endcase
        end
        span = (sb.retry_interval >= 32'h7FFFFFFF) ? 32'hFFFFFFFF : sb.retry_interval * 2 + 2;
        if ($urandom_range(0, 15) == 0) now_ms = $urandom;
        else now_ms = now_ms + $urandom_range(0, span);
        if (w.operation == OP_SCORE) w.time_now_ms = now_ms;
        return w;
    endfunction

    task automatic push_word(input t_in_word w);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_word(w);
    endtask

    // Drains the block; the extra cycles cover its two-stage pipeline.
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        logic [31:0] junk;
        logic [31:0] data;
        junk = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
        data = value;
        // Bits above a register's width must be dropped by the block.
        if (idx == CFG_ITERATION_LIMIT) data = {junk[31:10], value[9:0]};
        else if (idx != CFG_RETRY_INTERVAL_MS) data = {junk[31:16], value[15:0]};
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_register(idx, data);
        @(posedge i_clk);
    endtask

    task automatic apply_phase_settings(input int unsigned p);
        logic [9:0]  lim;
        logic [15:0] miss;
        logic [15:0] good;
        logic [15:0] semi;
        logic [15:0] recov;
        logic [31:0] retry;
        lim   = (p == 1) ? 10'd0 : (p == 2) ? 10'd1023 : 10'($urandom_range(1, 60));
        miss  = (p == 3) ? 16'd0 : (p == 4) ? COUNT_MAX : 16'($urandom_range(1, 4));
        good  = (p == 5) ? 16'd0 : (p == 6) ? COUNT_MAX : 16'($urandom_range(400, 800));
        semi  = (p == 6) ? 16'd0 : (p == 5) ? COUNT_MAX : 16'($urandom_range(300, 700));
        recov = (p == 3) ? 16'd0 : (p == 7) ? COUNT_MAX : 16'($urandom_range(1, 12));
        retry = (p == 8) ? 32'd0 : (p == 9) ? 32'hFFFFFFFF : $urandom_range(0, 5000);
        if (p == 0) begin
            lim   = RST_ITERATION_LIMIT;
            miss  = RST_MISS_COUNT_NEEDED;
            good  = RST_GOOD_THRESHOLD;
            semi  = RST_SEMI_THRESHOLD;
            recov = RST_RECOVER_COUNT_NEEDED;
            retry = RST_RETRY_INTERVAL_MS;
        end
        write_reg(CFG_ITERATION_LIMIT, 32'(lim));
        write_reg(CFG_MISS_COUNT_NEEDED, 32'(miss));
        write_reg(CFG_GOOD_THRESHOLD, 32'(good));
        write_reg(CFG_SEMI_THRESHOLD, 32'(semi));
        write_reg(CFG_RECOVER_COUNT_NEEDED, 32'(recov));
        write_reg(CFG_RETRY_INTERVAL_MS, retry);
        if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE_HI, $urandom);
    endtask

    initial begin : stimulus
        logic [31:0] t;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Score bookkeeping in normal mode, at and around the thresholds.
        push_word(score_word(16'd0, 32'd0));
        push_word(score_word(16'd512, 32'd5));
        push_word(score_word(16'd589, 32'd10));
        push_word(score_word(16'hFFFF, 32'd15));
        push_word(iteration_word(10'd20));
        push_word(iteration_word(10'd0));
        push_word(iteration_word(10'd21));
        // In backup now; an iteration report never raises a request.
        push_word(iteration_word(10'd1023));
        push_word(score_word(16'd100, 32'd1000));
        push_word(score_word(16'd100, 32'd81000));
        push_word(score_word(16'd100, 32'd81001));
        push_word(score_word(16'd100, 32'hFFFFFFF0));
        push_word(score_word(16'd100, 32'h00014000));
        t = 32'h00100000;
        repeat (6) begin
            push_word(score_word(16'd600, t));
            t = t + 32'd200000;
        end
        settle();
        write_reg(CFG_RECOVER_COUNT_NEEDED, 32'd3);
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        push_word(score_word(16'd600, t));
        push_word(iteration_word(10'd30));
        // The timer stays armed across the mode changes.
        push_word(score_word(16'd0, t + 32'd400000));
        settle();
        write_reg(CFG_MISS_COUNT_NEEDED, 32'd0);
        write_reg(CFG_RECOVER_COUNT_NEEDED, 32'd0);
        push_word(score_word(16'd0, 32'hFFFFFFFF));
        push_word(iteration_word(10'd0));
        push_word(iteration_word(10'd0));

        for (int p = 0; p < PHASES; p++) begin
            settle();
            apply_phase_settings(p);
            mood = t_mood'($urandom_range(0, 1));
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % 20 == 0) calm = ($urandom_range(0, 3) == 0);
                push_word(next_word());
            end
        end
        calm = 1'b0;
        settle();

        $display("checked %0d result words against %0d inputs: %0d mode switches, %0d reinit",
                 sb.checked, sb.words_in, sb.switches, sb.reinits);
        $display("requests, timer wrap and every register at its extremes");
        if (sb.mismatches == 0 && sb.pending_status.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d words never returned",
                     sb.mismatches, sb.pending_status.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
